/* rtl/lpfd_pkg.sv */
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types, constants and the error frame table of the deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int ERR_LEN = 7;
	localparam int MIN_HEADER = 2;
	localparam logic [15:0] MAX_FRAME_RESET = 16'd1024;

	typedef enum logic [3:0] {
		PH_HIGH = 4'b0001,
		PH_LOW  = 4'b0010,
		PH_PASS = 4'b0100,
		PH_DROP = 4'b1000
	} phase_t;

	typedef enum logic [1:0] {
		K_SINGLE = 2'd0,
		K_PAIR   = 2'd1,
		K_ERROR  = 2'd2
	} kind_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  b0;
		logic [7:0]  b1;
		logic [15:0] pos;
		logic        last;
	} desc_t;

	typedef struct packed {
		logic empty;
		logic full;
	} qstat_t;

	function automatic logic [7:0] err_byte(input logic [2:0] idx);
		logic [7:0] r;
		case (idx)
			3'd0: r = 8'h00;
			3'd1: r = 8'h00;
			3'd2: r = 8'h45;
			3'd3: r = 8'h52;
			3'd4: r = 8'h52;
			3'd5: r = 8'h4F;
			3'd6: r = 8'h52;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

endpackage

/* rtl/lpfd_ctrl.sv */
// ----------------------------------------------------------------------------
// lpfd_ctrl
// Frame state and limit register; turns requests that produce output into result descriptors.
// ----------------------------------------------------------------------------
module lpfd_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr,
	input  logic [15:0]      cfg_data,
	input  logic             accept,
	input  logic             command,
	input  logic [7:0]       data_byte,
	output logic             push,
	output lpfd_pkg::desc_t  push_desc
);

	lpfd_pkg::phase_t phase_q, phase_d;
	logic [7:0]  header_high_q, header_high_d;
	logic [15:0] frame_length_q, frame_length_d;
	logic [15:0] byte_count_q, byte_count_d;
	logic [15:0] max_frame_bytes_q;
	logic [15:0] cnt_inc;
	logic [15:0] len_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_frame_bytes_q <= lpfd_pkg::MAX_FRAME_RESET;
		end else if (cfg_wr) begin
			max_frame_bytes_q <= cfg_data;
		end
	end

	assign cnt_inc = byte_count_q + 16'd1;
	assign len_new = {header_high_q, data_byte};

	always_comb begin
		phase_d = phase_q;
		header_high_d = header_high_q;
		frame_length_d = frame_length_q;
		byte_count_d = byte_count_q;
		push = 1'b0;
		push_desc.kind = lpfd_pkg::K_SINGLE;
		push_desc.b0 = data_byte;
		push_desc.b1 = data_byte;
		push_desc.pos = byte_count_q;
		push_desc.last = 1'b0;
		if (accept) begin
			if (command) begin
				phase_d = lpfd_pkg::PH_HIGH;
				header_high_d = 8'd0;
				frame_length_d = 16'd0;
				byte_count_d = 16'd0;
			end else if (max_frame_bytes_q >= 16'(lpfd_pkg::ERR_LEN)) begin
				case (phase_q)
					lpfd_pkg::PH_HIGH: begin
						header_high_d = data_byte;
						byte_count_d = 16'd1;
						phase_d = lpfd_pkg::PH_LOW;
					end
					lpfd_pkg::PH_LOW: begin
						frame_length_d = len_new;
						byte_count_d = 16'(lpfd_pkg::MIN_HEADER);
						push_desc.kind = lpfd_pkg::K_PAIR;
						push_desc.b0 = header_high_q;
						if (len_new > max_frame_bytes_q) begin
							phase_d = lpfd_pkg::PH_DROP;
						end else if (len_new <= 16'(lpfd_pkg::MIN_HEADER)) begin
							push = 1'b1;
							push_desc.last = 1'b1;
							phase_d = lpfd_pkg::PH_HIGH;
							header_high_d = 8'd0;
							frame_length_d = 16'd0;
							byte_count_d = 16'd0;
						end else begin
							push = 1'b1;
							phase_d = lpfd_pkg::PH_PASS;
						end
					end
					lpfd_pkg::PH_PASS: begin
						push = 1'b1;
						byte_count_d = cnt_inc;
						if (cnt_inc >= frame_length_q) begin
							push_desc.last = 1'b1;
							phase_d = lpfd_pkg::PH_HIGH;
							header_high_d = 8'd0;
							frame_length_d = 16'd0;
							byte_count_d = 16'd0;
						end
					end
					lpfd_pkg::PH_DROP: begin
						byte_count_d = cnt_inc;
						if (cnt_inc >= frame_length_q) begin
							push = 1'b1;
							push_desc.kind = lpfd_pkg::K_ERROR;
							phase_d = lpfd_pkg::PH_HIGH;
							header_high_d = 8'd0;
							frame_length_d = 16'd0;
							byte_count_d = 16'd0;
						end
					end
					default: begin
						phase_d = lpfd_pkg::PH_HIGH;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= lpfd_pkg::PH_HIGH;
			header_high_q <= 8'd0;
			frame_length_q <= 16'd0;
			byte_count_q <= 16'd0;
		end else begin
			phase_q <= phase_d;
			header_high_q <= header_high_d;
			frame_length_q <= frame_length_d;
			byte_count_q <= byte_count_d;
		end
	end

endmodule

/* rtl/lpfd_queue.sv */
// ----------------------------------------------------------------------------
// lpfd_queue
// Two-entry descriptor queue between frame control and output serializer.
// ----------------------------------------------------------------------------
module lpfd_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  lpfd_pkg::desc_t  push_desc,
	input  logic             pop,
	output lpfd_pkg::desc_t  head,
	output lpfd_pkg::qstat_t st
);

	lpfd_pkg::desc_t entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	assign head = entry_q[rd_ptr_q];
	assign st.empty = (count_q == 2'd0);
	assign st.full = (count_q == 2'd2);

endmodule

/* rtl/lpfd_ser.sv */
// ----------------------------------------------------------------------------
// lpfd_ser
// Expands queued descriptors into result bytes held in the output register.
// ----------------------------------------------------------------------------
module lpfd_ser (
	input  logic             clk,
	input  logic             arst_n,
	input  lpfd_pkg::desc_t  head,
	input  lpfd_pkg::qstat_t st,
	input  logic             out_stall,
	output logic             pop,
	output logic             out_valid,
	output logic [7:0]       out_byte,
	output logic [15:0]      frame_pos,
	output logic             last,
	output logic             error_frame
);

	logic [2:0]  idx_q;
	logic [2:0]  last_idx;
	logic        load;
	logic        out_valid_q;
	logic [7:0]  byte_nx;
	logic [15:0] pos_nx;
	logic        last_nx;
	logic        err_nx;
	logic [7:0]  out_byte_q;
	logic [15:0] frame_pos_q;
	logic        last_q;
	logic        error_frame_q;

	assign load = !st.empty && (!out_valid_q || !out_stall);

	always_comb begin
		last_idx = 3'd0;
		byte_nx = head.b0;
		pos_nx = head.pos;
		last_nx = head.last;
		err_nx = 1'b0;
		case (head.kind)
			lpfd_pkg::K_SINGLE: begin
				last_idx = 3'd0;
			end
			lpfd_pkg::K_PAIR: begin
				last_idx = 3'd1;
				byte_nx = (idx_q == 3'd0) ? head.b0 : head.b1;
				pos_nx = {13'd0, idx_q};
				last_nx = (idx_q == 3'd0) ? 1'b0 : head.last;
			end
			lpfd_pkg::K_ERROR: begin
				last_idx = 3'(lpfd_pkg::ERR_LEN - 1);
				byte_nx = lpfd_pkg::err_byte(idx_q);
				pos_nx = {13'd0, idx_q};
				last_nx = (idx_q == 3'(lpfd_pkg::ERR_LEN - 1));
				err_nx = 1'b1;
			end
			default: begin
				last_idx = 3'd0;
			end
		endcase
	end

	assign pop = load && (idx_q == last_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q <= pop ? 3'd0 : idx_q + 3'd1;
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_byte_q <= byte_nx;
			frame_pos_q <= pos_nx;
			last_q <= last_nx;
			error_frame_q <= err_nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_byte = out_byte_q;
	assign frame_pos = frame_pos_q;
	assign last = last_q;
	assign error_frame = error_frame_q;

endmodule

/* rtl/length_prefixed_frame_deframer.sv */
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Length-prefixed byte stream deframer with oversize error frame substitution.
// ----------------------------------------------------------------------------
// channel  dir  handshake           payload
// in       in   in_valid/in_stall   command, data_byte
// out      out  out_valid/out_stall out_byte, frame_pos, last, error_frame
// cfg      in   cfg_valid/cfg_ready cfg_data (max_frame_bytes)
//
// one request per cycle is taken while in_stall is low; results leave the
// output register one per cycle while out_stall is low, so a second header
// byte yields two result bytes and a discarded frame's end seven. a two-entry
// descriptor queue sits between frame control and serializer; in_stall is
// high while it is full. reset clears the frame state, empties the queue and
// sets the limit to 1024. cfg_ready is always high.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        command,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [7:0]  out_byte,
	output logic [15:0] frame_pos,
	output logic        last,
	output logic        error_frame,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [15:0] cfg_data
);

	logic             accept;
	logic             push;
	logic             pop;
	lpfd_pkg::desc_t  push_desc;
	lpfd_pkg::desc_t  head;
	lpfd_pkg::qstat_t q_st;

	assign cfg_ready = 1'b1;
	assign in_stall = q_st.full;
	assign accept = in_valid && !in_stall;

	lpfd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr    (cfg_valid && cfg_ready),
		.cfg_data  (cfg_data),
		.accept    (accept),
		.command   (command),
		.data_byte (data_byte),
		.push      (push),
		.push_desc (push_desc)
	);

	lpfd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_desc (push_desc),
		.pop       (pop),
		.head      (head),
		.st        (q_st)
	);

	lpfd_ser u_ser (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (head),
		.st          (q_st),
		.out_stall   (out_stall),
		.pop         (pop),
		.out_valid   (out_valid),
		.out_byte    (out_byte),
		.frame_pos   (frame_pos),
		.last        (last),
		.error_frame (error_frame)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_st.full)
		else $error("descriptor written into a full queue");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_st.empty)
		else $error("descriptor taken from an empty queue");

	a_err_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && error_frame && last |-> frame_pos == 16'(lpfd_pkg::ERR_LEN - 1))
		else $error("error frame ends at a wrong offset");

endmodule

/* test/tb_length_prefixed_frame_deframer.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_length_prefixed_frame_deframer
// Self-checking bench for the length-prefixed deframer. A short table of
// directed requests covers headers, short lengths, aborts, the oversize
// error frame, the limit extremes and a limit change mid-frame. A random
// phase then sweeps the limit and sends framed streams with random content,
// mixed with broken frames and noise. Every result is checked against an
// in-bench predictor while both sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_length_prefixed_frame_deframer;

	localparam int STALL_LIMIT = 1000;
	localparam int RAND_REQS = 40;
	localparam int HOLD_CYCLES = 80;
	localparam logic [7:0] ERR_TEXT [0:6] = '{8'h00, 8'h00, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52};

	typedef struct packed {
		logic [7:0]  ob;
		logic [15:0] pos;
		logic        lst;
		logic        err;
	} frame_byte_t;

	typedef enum logic {
		STEP_BYTE,
		STEP_LIMIT
	} step_kind_t;

	typedef struct packed {
		step_kind_t  kind;
		logic        cmd;
		logic [15:0] val;
		logic        typed;
		frame_byte_t want;
	} step_t;

	localparam frame_byte_t NO_WANT = '0;

	localparam step_t DIR_TAB [31] = '{
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0005, 1'b1, '{8'h05, 16'd1, 1'b0, 1'b0}},
		'{STEP_BYTE,  1'b0, 16'h00FF, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h00A5, 1'b1, '{8'hA5, 16'd4, 1'b1, 1'b0}},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b1, '{8'h00, 16'd1, 1'b1, 1'b0}},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b1, 16'h00FF, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0003, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h007E, 1'b1, '{8'h7E, 16'd2, 1'b1, 1'b0}},
		'{STEP_LIMIT, 1'b0, 16'h0007, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0008, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0011, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0012, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0013, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0014, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0015, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0016, 1'b1, '{8'h52, 16'd6, 1'b1, 1'b1}},
		'{STEP_LIMIT, 1'b0, 16'hFFFF, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h00FF, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h00FF, 1'b1, '{8'hFF, 16'd1, 1'b0, 1'b0}},
		'{STEP_BYTE,  1'b0, 16'h003C, 1'b0, NO_WANT},
		'{STEP_LIMIT, 1'b0, 16'h0007, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h00C3, 1'b1, '{8'hC3, 16'd3, 1'b0, 1'b0}},
		'{STEP_BYTE,  1'b1, 16'h0000, 1'b0, NO_WANT},
		'{STEP_LIMIT, 1'b0, 16'h0006, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0000, 1'b0, NO_WANT},
		'{STEP_BYTE,  1'b0, 16'h0002, 1'b0, NO_WANT}
	};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        command = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [7:0]  out_byte;
	logic [15:0] frame_pos;
	logic        last;
	logic        error_frame;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [15:0] cfg_data = 16'h0000;

	// deframer prediction state
	lpfd_pkg::phase_t ph = lpfd_pkg::PH_HIGH;
	logic [7:0]  hdr_hi = 8'h00;
	logic [15:0] flen = 16'h0000;
	logic [15:0] cnt = 16'h0000;
	logic [15:0] max_len = lpfd_pkg::MAX_FRAME_RESET;
	frame_byte_t pending_bytes [$];

	int  mismatches = 0;
	int  live_reqs = 0;
	int  results_seen = 0;
	int  error_frames = 0;
	int  limit_writes = 0;
	int  burst_left = 0;
	bit  hold_req = 1'b0;

	length_prefixed_frame_deframer dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.command(command),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_byte(out_byte),
		.frame_pos(frame_pos),
		.last(last),
		.error_frame(error_frame),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	always #6 clk = ~clk;

	function automatic void restart_frame();
		ph = lpfd_pkg::PH_HIGH;
		hdr_hi = 8'h00;
		flen = 16'h0000;
		cnt = 16'h0000;
	endfunction

	function automatic void add_byte(input logic [7:0] b, input logic [15:0] pos,
		input logic lst, input logic err);
		frame_byte_t e;
		e.ob = b;
		e.pos = pos;
		e.lst = lst;
		e.err = err;
		pending_bytes.push_back(e);
	endfunction

	function automatic void deframe_byte(input logic cmd, input logic [7:0] b);
		logic [15:0] pos;
		if (cmd) begin
			restart_frame();
			return;
		end
		if (max_len < lpfd_pkg::ERR_LEN)
			return;
		case (ph)
			lpfd_pkg::PH_HIGH: begin
				hdr_hi = b;
				cnt = 16'd1;
				ph = lpfd_pkg::PH_LOW;
			end
			lpfd_pkg::PH_LOW: begin
				flen = {hdr_hi, b};
				cnt = 16'd2;
				if (flen > max_len) begin
					ph = lpfd_pkg::PH_DROP;
				end else begin
					add_byte(hdr_hi, 16'd0, 1'b0, 1'b0);
					add_byte(b, 16'd1, flen <= lpfd_pkg::MIN_HEADER, 1'b0);
					if (flen <= lpfd_pkg::MIN_HEADER)
						restart_frame();
					else
						ph = lpfd_pkg::PH_PASS;
				end
			end
			lpfd_pkg::PH_PASS: begin
				pos = cnt;
				cnt = cnt + 16'd1;
				add_byte(b, pos, cnt >= flen, 1'b0);
				if (cnt >= flen)
					restart_frame();
			end
			default: begin
				cnt = cnt + 16'd1;
				if (cnt >= flen) begin
					for (int k = 0; k < lpfd_pkg::ERR_LEN; k++)
						add_byte(ERR_TEXT[k], 16'(k), k == lpfd_pkg::ERR_LEN - 1, 1'b1);
					restart_frame();
				end
			end
		endcase
	endfunction

	function automatic void check_field(input string name, input logic [15:0] want,
		input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %0h got %0h", $time, name, want, got);
			mismatches++;
		end
	endfunction

	// called at a falling edge, returns at a falling edge
	task automatic send_item(input logic cmd, input logic [7:0] b, input logic typed,
		input frame_byte_t want);
		int n_prior;
		int gap;
		in_valid <= 1'b1;
		command <= cmd;
		data_byte <= b;
		do @(posedge clk); while (in_stall);
		if (cmd || max_len >= lpfd_pkg::ERR_LEN)
			live_reqs++;
		n_prior = pending_bytes.size();
		deframe_byte(cmd, b);
		if (typed) begin
			if (pending_bytes.size() == n_prior) begin
				$display("%0t: out_byte expected %0h got no result predicted", $time, want.ob);
				mismatches++;
			end else begin
				pending_bytes[pending_bytes.size() - 1] = want;
			end
		end
		@(negedge clk);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end else begin
			burst_left--;
		end
	endtask

	task automatic write_max(input logic [15:0] v);
		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		max_len = v;
		limit_writes++;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_frame();
		int sel;
		int lim;
		int cut;
		int n;
		logic [15:0] len;
		sel = $urandom_range(0, 9);
		lim = (max_len < 48) ? max_len : 48;
		cut = $urandom_range(0, 5) - 1;
		if (sel < 2)
			len = 16'($urandom_range(0, 2));
		else if (sel < 7 || (sel < 9 && max_len > 16'hFFF0))
			len = 16'($urandom_range(3, lim));
		else if (sel < 9)
			len = max_len + 16'($urandom_range(1, 12));
		else
			len = 16'($urandom_range(0, 65535));
		send_item(1'b0, len[15:8], 1'b0, NO_WANT);
		if (sel == 9 && cut < 0) begin
			send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
			return;
		end
		send_item(1'b0, len[7:0], 1'b0, NO_WANT);
		n = (len > 2) ? len - 2 : 0;
		if (sel == 9 && cut < n)
			n = cut;
		repeat (n) send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
		// random-length frame: ended by an abort, which cuts it short unless it is complete
		if (sel == 9)
			send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
	endtask

	// receiver stall pattern
	initial begin
		int hold_left;
		int mode;
		int mode_left;
		bit hold_taken;
		logic [7:0] pat;
		hold_left = 0;
		mode = 0;
		mode_left = 0;
		hold_taken = 1'b0;
		pat = 8'($urandom_range(0, 255));
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				if (mode_left == 0) begin
					mode = $urandom_range(0, 2);
					mode_left = $urandom_range(8, 40);
				end
				mode_left--;
				case (mode)
					0: out_stall <= 1'b0;
					1: out_stall <= ($urandom_range(0, 2) == 0);
					default: begin
						out_stall <= pat[0];
						pat = {pat[0], pat[7:1]};
					end
				endcase
			end
		end
	end

	// result checker
	always @(posedge clk) begin
		frame_byte_t e;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			results_seen++;
			if (last && error_frame)
				error_frames++;
			if (pending_bytes.size() == 0) begin
				$display("%0t: out_byte expected none got %0h", $time, out_byte);
				mismatches++;
			end else begin
				e = pending_bytes.pop_front();
				check_field("out_byte", e.ob, out_byte);
				check_field("frame_pos", e.pos, frame_pos);
				check_field("last", e.lst, last);
				check_field("error_frame", e.err, error_frame);
			end
		end
	end

	// watchdog
	initial begin
		int idle;
		idle = 0;
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid === 1'b1 && !out_stall)
				|| (cfg_valid && cfg_ready))
				idle = 0;
			else
				idle++;
		end
		$display("%0t: watchdog, no request moved for %0d cycles", $time, STALL_LIMIT);
		$display("FAIL");
		$finish;
	end

	initial begin
		int live_base;
		int sel;
		bit first;
		logic [15:0] v;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(DIR_TAB); i++) begin
			if (DIR_TAB[i].kind == STEP_LIMIT)
				write_max(DIR_TAB[i].val);
			else
				send_item(DIR_TAB[i].cmd, DIR_TAB[i].val[7:0], DIR_TAB[i].typed,
					DIR_TAB[i].want);
		end

		live_base = live_reqs;
		first = 1'b1;
		while (live_reqs < live_base + RAND_REQS) begin
			sel = $urandom_range(0, 9);
			if (first)
				v = 16'($urandom_range(20, 48));
			else if (sel == 0)
				v = 16'd7;
			else if (sel == 1)
				v = 16'hFFFF;
			else if (sel == 2)
				v = 16'($urandom_range(0, 6));
			else
				v = 16'($urandom_range(7, 48));
			write_max(v);
			if (first)
				hold_req = 1'b1;
			first = 1'b0;
			if (v < lpfd_pkg::ERR_LEN) begin
				repeat ($urandom_range(1, 4))
					send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
			end else begin
				repeat ($urandom_range(2, 5)) begin
					if ($urandom_range(0, 5) == 0) begin
						// noise bytes, then an abort to resync
						repeat ($urandom_range(1, 3))
							send_item(1'b0, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
						send_item(1'b1, 8'($urandom_range(0, 255)), 1'b0, NO_WANT);
					end else begin
						send_frame();
					end
				end
			end
		end

		in_valid <= 1'b0;
		while (pending_bytes.size() != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);
		$display("covered %0d requests and %0d result bytes, %0d of them closing error frames",
			live_reqs, results_seen, error_frames);
		$display("limit written %0d times, low, high and mid-frame settings included",
			limit_writes);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

/* length_prefixed_frame_deframer.f */
rtl/lpfd_pkg.sv
rtl/lpfd_ctrl.sv
rtl/lpfd_queue.sv
rtl/lpfd_ser.sv
rtl/length_prefixed_frame_deframer.sv
test/tb_length_prefixed_frame_deframer.sv
